### src/swm2_pkg.sv
package swm2_pkg;

    localparam int MAX_WINDOW_DEF  = 8;
    localparam int MAX_WIDTH_DEF   = 1024;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int HEIGHT_LIMIT  = 1024;
    localparam int COORD_BITS    = 10;
    localparam int WIN_BITS      = 4;
    localparam int DIM_BITS      = 11;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [WIN_BITS-1:0] WINDOW_SIZE_RST = 4'd2;
    localparam logic [DIM_BITS-1:0] DIM_RST         = 11'd1024;

    // clamped register values, plus a one-cycle pulse that restarts the frame
    typedef struct packed {
        logic [WIN_BITS-1:0] k;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        logic                restart;
    } cfg_t;

    typedef struct packed {
        logic                  do_h;
        logic                  do_v;
        logic                  last;
        logic [COORD_BITS-1:0] out_row;
        logic [COORD_BITS-1:0] out_col;
    } item_ctl_t;

endpackage

### src/swm2_ram.sv
module swm2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first on a same-address collision
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/swm2_cfg.sv
module swm2_cfg #(
    parameter int MAX_WINDOW = swm2_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH  = swm2_pkg::MAX_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swm2_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [swm2_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [swm2_pkg::CFG_DATA_BITS-1:0] prdata,
    output swm2_pkg::cfg_t                     cfg
);

    logic [swm2_pkg::WIN_BITS-1:0] window_size_reg;
    logic [swm2_pkg::DIM_BITS-1:0] image_width_reg;
    logic [swm2_pkg::DIM_BITS-1:0] image_height_reg;
    logic                          wr_en;
    logic [1:0]                    reg_idx;
    logic                          reg_hit;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign reg_hit = (reg_idx == swm2_pkg::REG_WINDOW_SIZE) ||
                     (reg_idx == swm2_pkg::REG_IMAGE_WIDTH) ||
                     (reg_idx == swm2_pkg::REG_IMAGE_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= swm2_pkg::WINDOW_SIZE_RST;
            image_width_reg  <= swm2_pkg::DIM_RST;
            image_height_reg <= swm2_pkg::DIM_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                swm2_pkg::REG_WINDOW_SIZE: begin
                    window_size_reg <= pwdata[swm2_pkg::WIN_BITS-1:0];
                end
                swm2_pkg::REG_IMAGE_WIDTH: begin
                    image_width_reg <= pwdata[swm2_pkg::DIM_BITS-1:0];
                end
                swm2_pkg::REG_IMAGE_HEIGHT: begin
                    image_height_reg <= pwdata[swm2_pkg::DIM_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            swm2_pkg::REG_WINDOW_SIZE:  prdata = swm2_pkg::CFG_DATA_BITS'(window_size_reg);
            swm2_pkg::REG_IMAGE_WIDTH:  prdata = swm2_pkg::CFG_DATA_BITS'(image_width_reg);
            swm2_pkg::REG_IMAGE_HEIGHT: prdata = swm2_pkg::CFG_DATA_BITS'(image_height_reg);
            default:                    prdata = '0;
        endcase
    end

    always_comb begin
        if (window_size_reg == '0) begin
            cfg.k = swm2_pkg::WIN_BITS'(1);
        end else if (32'(window_size_reg) > MAX_WINDOW) begin
            cfg.k = swm2_pkg::WIN_BITS'(MAX_WINDOW);
        end else begin
            cfg.k = window_size_reg;
        end

        if (image_width_reg == '0) begin
            cfg.w = swm2_pkg::DIM_BITS'(1);
        end else if (32'(image_width_reg) > MAX_WIDTH) begin
            cfg.w = swm2_pkg::DIM_BITS'(MAX_WIDTH);
        end else begin
            cfg.w = image_width_reg;
        end

        if (image_height_reg == '0) begin
            cfg.h = swm2_pkg::DIM_BITS'(1);
        end else if (32'(image_height_reg) > swm2_pkg::HEIGHT_LIMIT) begin
            cfg.h = swm2_pkg::DIM_BITS'(swm2_pkg::HEIGHT_LIMIT);
        end else begin
            cfg.h = image_height_reg;
        end

        cfg.restart = wr_en && reg_hit;
    end

endmodule

### src/swm2_row_max.sv
module swm2_row_max #(
    parameter int MAX_WINDOW  = swm2_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH   = swm2_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = swm2_pkg::SAMPLE_BITS_DEF,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int LINE_ROWS  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1,
    localparam int SW         = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swm2_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          st_valid,
    input  logic                          st_ready,
    output logic signed [SAMPLE_BITS-1:0] st_hmax,
    output logic [CW-1:0]                 st_col,
    output logic [SW-1:0]                 st_slot,
    output swm2_pkg::item_ctl_t           st_ctl
);

    logic [CW-1:0]                   col_reg;
    logic [swm2_pkg::COORD_BITS-1:0] row_reg;
    logic [SW-1:0]                   slot_reg;
    logic signed [SAMPLE_BITS-1:0]   hist_reg [MAX_WINDOW];
    logic                            valid_reg;
    logic [CW-1:0]                   col1_reg;
    logic [SW-1:0]                   slot1_reg;
    swm2_pkg::item_ctl_t             ctl_reg;
    swm2_pkg::item_ctl_t             ctl_next;
    logic                            accept;
    logic                            col_last;
    logic                            row_last;
    logic                            slot_last;

    assign in_ready = !valid_reg || st_ready;
    assign accept   = in_valid && in_ready;

    assign col_last  = (32'(col_reg) + 1) >= 32'(cfg.w);
    assign row_last  = (32'(row_reg) + 1) >= 32'(cfg.h);
    assign slot_last = (32'(slot_reg) + 1) >= LINE_ROWS;

    always_comb begin
        ctl_next.do_h    = (32'(cfg.w) >= 32'(cfg.k)) && ((32'(col_reg) + 1) >= 32'(cfg.k));
        ctl_next.do_v    = ctl_next.do_h && (32'(cfg.h) >= 32'(cfg.k)) &&
                           ((32'(row_reg) + 1) >= 32'(cfg.k));
        ctl_next.last    = row_last && col_last;
        ctl_next.out_row = swm2_pkg::COORD_BITS'(32'(row_reg) + 1 - 32'(cfg.k));
        ctl_next.out_col = swm2_pkg::COORD_BITS'(32'(col_reg) + 1 - 32'(cfg.k));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            row_reg   <= '0;
            slot_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cfg.restart) begin
                col_reg  <= '0;
                row_reg  <= '0;
                slot_reg <= '0;
            end else if (accept) begin
                col_reg <= col_last ? '0 : col_reg + 1'b1;
                if (col_last) begin
                    row_reg  <= row_last ? '0 : row_reg + 1'b1;
                    slot_reg <= (row_last || slot_last) ? '0 : slot_reg + 1'b1;
                end
            end
            if (in_ready) begin
                valid_reg <= in_valid;
            end
        end
    end

    // hist_reg[0] is the sample held in this stage, higher taps are older ones
    always_ff @(posedge aclk) begin
        if (accept) begin
            hist_reg[0] <= in_sample;
            for (int j = 1; j < MAX_WINDOW; j++) begin
                hist_reg[j] <= hist_reg[j-1];
            end
            col1_reg  <= col_reg;
            slot1_reg <= slot_reg;
            ctl_reg   <= ctl_next;
        end
    end

    always_comb begin
        st_hmax = hist_reg[0];
        for (int j = 1; j < MAX_WINDOW; j++) begin
            if ((j < 32'(cfg.k)) && (hist_reg[j] > st_hmax)) begin
                st_hmax = hist_reg[j];
            end
        end
    end

    assign st_valid = valid_reg;
    assign st_col   = col1_reg;
    assign st_slot  = slot1_reg;
    assign st_ctl   = ctl_reg;

endmodule

### src/swm2_col_max.sv
module swm2_col_max #(
    parameter int MAX_WINDOW  = swm2_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH   = swm2_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = swm2_pkg::SAMPLE_BITS_DEF,
    localparam int CW         = $clog2(MAX_WIDTH),
    localparam int LINE_ROWS  = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1,
    localparam int SW         = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1,
    localparam int DW         = $clog2(LINE_ROWS + 1),
    localparam int TOUT_BITS  = ((SAMPLE_BITS + 2 * swm2_pkg::COORD_BITS + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swm2_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_hmax,
    input  logic [CW-1:0]                 in_col,
    input  logic [SW-1:0]                 in_slot,
    input  swm2_pkg::item_ctl_t           in_ctl,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [TOUT_BITS-1:0]          m_tdata,
    output logic                          m_tlast
);

    logic                            v2_reg;
    logic signed [SAMPLE_BITS-1:0]   hmax2_reg;
    logic [SW-1:0]                   slot2_reg;
    swm2_pkg::item_ctl_t             ctl2_reg;
    logic                            mv_reg;
    logic signed [SAMPLE_BITS-1:0]   max_reg;
    logic [swm2_pkg::COORD_BITS-1:0] row_reg;
    logic [swm2_pkg::COORD_BITS-1:0] col_reg;
    logic                            last_reg;
    logic [SAMPLE_BITS-1:0]          rd_data [LINE_ROWS];
    logic signed [SAMPLE_BITS-1:0]   vmax;
    logic                            adv;
    logic                            out_free;
    logic                            s2_adv;

    assign out_free = !mv_reg || m_tready;
    assign s2_adv   = v2_reg && (!ctl2_reg.do_v || out_free);
    assign in_ready = !v2_reg || s2_adv;
    assign adv      = in_valid && in_ready;

    // one line buffer per row slot; the current row's slot is read before it is written
    for (genvar s = 0; s < LINE_ROWS; s++) begin : g_line
        swm2_ram #(
            .WIDTH (SAMPLE_BITS),
            .DEPTH (MAX_WIDTH)
        ) u_ram (
            .aclk  (aclk),
            .we    (adv && in_ctl.do_h && (MAX_WINDOW > 1) && (32'(in_slot) == s)),
            .waddr (in_col),
            .wdata (in_hmax),
            .re    (adv),
            .raddr (in_col),
            .rdata (rd_data[s])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                v2_reg <= in_valid;
            end
            if (out_free) begin
                mv_reg <= v2_reg && ctl2_reg.do_v;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            hmax2_reg <= in_hmax;
            slot2_reg <= in_slot;
            ctl2_reg  <= in_ctl;
        end
        if (out_free && v2_reg && ctl2_reg.do_v) begin
            max_reg  <= vmax;
            row_reg  <= ctl2_reg.out_row;
            col_reg  <= ctl2_reg.out_col;
            last_reg <= ctl2_reg.last;
        end
    end

    // slot distance d holds the row d above the current one
    always_comb begin
        logic [DW-1:0] slot_gap;
        vmax = hmax2_reg;
        for (int s = 0; s < LINE_ROWS; s++) begin
            if (32'(slot2_reg) > s) begin
                slot_gap = DW'(32'(slot2_reg) - s);
            end else begin
                slot_gap = DW'(32'(slot2_reg) + LINE_ROWS - s);
            end
            if ((32'(slot_gap) < 32'(cfg.k)) && ($signed(rd_data[s]) > vmax)) begin
                vmax = $signed(rd_data[s]);
            end
        end
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = TOUT_BITS'({col_reg, row_reg, max_reg});
    assign m_tlast  = last_reg;

endmodule

### src/sliding_window_max_2d.sv
// Stride-1 k x k max pooling over a raster-order stream of signed samples.
// One sample is taken per clock unless the output stalls; a result passes
// the row-max stage register, the column-max stage register and the output
// register, carrying the window maximum and the window's top-left row and
// column, with tlast on the last result of a frame. Earlier rows' row
// maxima sit in MAX_WINDOW-1 line buffers of MAX_WIDTH words, read on every
// beat and written on beats that complete a row maximum. No clearing pass
// runs after reset. A write to any of the three registers restarts the
// frame at row 0, column 0; write registers only while the block is idle.
// Images narrower or shorter than k give no results.
module sliding_window_max_2d #(
    parameter int MAX_WINDOW  = swm2_pkg::MAX_WINDOW_DEF,
    parameter int MAX_WIDTH   = swm2_pkg::MAX_WIDTH_DEF,
    parameter int SAMPLE_BITS = swm2_pkg::SAMPLE_BITS_DEF,
    localparam int TIN_BITS   = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int TOUT_BITS  = ((SAMPLE_BITS + 2 * swm2_pkg::COORD_BITS + 7) / 8) * 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [TIN_BITS-1:0]                s_tdata,   // sample
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [TOUT_BITS-1:0]               m_tdata,   // window_max, out_row, out_col
    output logic                               m_tlast,   // frame_end
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [swm2_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [swm2_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [swm2_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                               pready
);

    localparam int CW        = $clog2(MAX_WIDTH);
    localparam int LINE_ROWS = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int SW        = (LINE_ROWS > 1) ? $clog2(LINE_ROWS) : 1;

    swm2_pkg::cfg_t                cfg;
    logic                          st_valid;
    logic                          st_ready;
    logic signed [SAMPLE_BITS-1:0] st_hmax;
    logic [CW-1:0]                 st_col;
    logic [SW-1:0]                 st_slot;
    swm2_pkg::item_ctl_t           st_ctl;

    assign pready = 1'b1;

    swm2_cfg #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_WIDTH  (MAX_WIDTH)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    swm2_row_max #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_row_max (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .st_valid  (st_valid),
        .st_ready  (st_ready),
        .st_hmax   (st_hmax),
        .st_col    (st_col),
        .st_slot   (st_slot),
        .st_ctl    (st_ctl)
    );

    swm2_col_max #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_col_max (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .in_valid (st_valid),
        .in_ready (st_ready),
        .in_hmax  (st_hmax),
        .in_col   (st_col),
        .in_slot  (st_slot),
        .in_ctl   (st_ctl),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTHESIS
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid && !st_ready |=> st_valid && $stable(st_ctl) && $stable(st_col))
        else $error("row stage changed while stalled");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> st_valid)
        else $error("input stalled with empty row stage");

    a_vert_needs_row: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid && st_ctl.do_v |-> st_ctl.do_h)
        else $error("window result without row maximum");
`endif

endmodule

### verif/tb_sliding_window_max_2d.sv
`timescale 1ns / 100ps

module tb_sliding_window_max_2d;

    localparam int MAX_WIN      = swm2_pkg::MAX_WINDOW_DEF;
    localparam int MAX_W        = swm2_pkg::MAX_WIDTH_DEF;
    localparam int LINE_ROWS    = (MAX_WIN > 1) ? MAX_WIN - 1 : 1;
    localparam int TIN_W        = ((swm2_pkg::SAMPLE_BITS_DEF + 7) / 8) * 8;
    localparam int TOUT_W       = ((swm2_pkg::SAMPLE_BITS_DEF + 2 * swm2_pkg::COORD_BITS + 7)
                                   / 8) * 8;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int RANDOM_ITEMS = 100;

    typedef struct packed {
        logic signed [15:0]              window_max;
        logic [swm2_pkg::COORD_BITS-1:0] out_row;
        logic [swm2_pkg::COORD_BITS-1:0] out_col;
        logic                            frame_end;
    } pooled_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [TIN_W-1:0]                    s_tdata = '0;   // sample
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [TOUT_W-1:0]                   m_tdata;        // window_max, out_row, out_col
    logic                                m_tlast;        // frame_end
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [swm2_pkg::CFG_ADDR_BITS-1:0]  paddr = '0;
    logic [swm2_pkg::CFG_DATA_BITS-1:0]  pwdata = '0;
    logic [swm2_pkg::CFG_DATA_BITS-1:0]  prdata;
    logic                                pready;

    // pooling predictor state
    logic [swm2_pkg::WIN_BITS-1:0] cfg_k = swm2_pkg::WINDOW_SIZE_RST;
    logic [swm2_pkg::DIM_BITS-1:0] cfg_w = swm2_pkg::DIM_RST;
    logic [swm2_pkg::DIM_BITS-1:0] cfg_h = swm2_pkg::DIM_RST;
    logic [swm2_pkg::DIM_BITS-1:0] col_pos = '0;
    logic [swm2_pkg::DIM_BITS-1:0] row_pos = '0;
    logic signed [15:0]            row_samples [0:MAX_WIN-1];
    logic signed [15:0]            row_maxima [0:LINE_ROWS-1][0:MAX_W-1];
    pooled_t                       pending_windows [$];

    int samples_sent = 0;
    int windows_seen = 0;
    int reg_writes = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int src_idle_pct = 0;
    int sink_idle_pct = 0;
    int sink_stall_left = 0;

    sliding_window_max_2d u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d windows still pending",
                     cycle_count, pending_windows.size());
            $display("sliding_window_max_2d test failed");
            $finish;
        end
    end

    function automatic int pick_gap(input int pct);
        if ($urandom_range(99) >= pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic int eff_window(input logic [swm2_pkg::WIN_BITS-1:0] k);
        if (k == 0)
            return 1;
        if (k > MAX_WIN)
            return MAX_WIN;
        return k;
    endfunction

    function automatic int eff_dim(input logic [swm2_pkg::DIM_BITS-1:0] d, input int hi);
        if (d == 0)
            return 1;
        if (d > hi)
            return hi;
        return d;
    endfunction

    function automatic logic signed [15:0] pick_sample(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'(int'($urandom_range(8)) - 4);
            default: begin
                case ($urandom_range(3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    default: return 16'($urandom);
                endcase
            end
        endcase
    endfunction

    // separable max: row max over k samples, then column max over k row maxima
    function automatic void predict_window(input logic signed [15:0] s);
        int k, w, h, c, r;
        logic signed [15:0] hmax, vmax;
        pooled_t want;
        k = eff_window(cfg_k);
        w = eff_dim(cfg_w, MAX_W);
        h = eff_dim(cfg_h, swm2_pkg::HEIGHT_LIMIT);
        c = col_pos;
        r = row_pos;
        if (c >= w)
            c = 0;
        if (r >= h)
            r = 0;
        row_samples[c % MAX_WIN] = s;
        if (w >= k && c + 1 >= k) begin
            hmax = s;
            for (int j = 1; j < k; j++)
                if (row_samples[(c - j) % MAX_WIN] > hmax)
                    hmax = row_samples[(c - j) % MAX_WIN];
            if (h >= k && r + 1 >= k) begin
                vmax = hmax;
                for (int i = 1; i < k; i++)
                    if (row_maxima[(r - i) % LINE_ROWS][c] > vmax)
                        vmax = row_maxima[(r - i) % LINE_ROWS][c];
                want.window_max = vmax;
                want.out_row    = swm2_pkg::COORD_BITS'(r + 1 - k);
                want.out_col    = swm2_pkg::COORD_BITS'(c + 1 - k);
                want.frame_end  = (r == h - 1) && (c == w - 1);
                pending_windows = {pending_windows, want};
            end
            row_maxima[r % LINE_ROWS][c] = hmax;
        end
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_pos = swm2_pkg::DIM_BITS'(c);
        row_pos = swm2_pkg::DIM_BITS'(r);
    endfunction

    task automatic report_mismatch(input string what, input int want_v, input int got_v);
        mismatches++;
        $display("[%0t] mismatch on %s: expected %0d, got %0d",
                 $time, what, want_v, got_v);
    endtask

    always @(negedge aclk) begin
        if (sink_stall_left > 0) begin
            sink_stall_left--;
            m_tready = 1'b0;
        end else begin
            sink_stall_left = pick_gap(sink_idle_pct);
            if (sink_stall_left > 0) begin
                sink_stall_left--;
                m_tready = 1'b0;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : score_windows
        pooled_t want;
        if (aresetn && m_tvalid && m_tready) begin
            windows_seen++;
            if (pending_windows.size() == 0) begin
                report_mismatch("unexpected result beat", 0, $signed(m_tdata[15:0]));
            end else begin
                want = pending_windows.pop_front();
                if (m_tdata[15:0] !== want.window_max)
                    report_mismatch("window_max", want.window_max, $signed(m_tdata[15:0]));
                if (m_tdata[25:16] !== want.out_row)
                    report_mismatch("out_row", want.out_row, m_tdata[25:16]);
                if (m_tdata[35:26] !== want.out_col)
                    report_mismatch("out_col", want.out_col, m_tdata[35:26]);
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame_end", want.frame_end, m_tlast);
                if (m_tdata[TOUT_W-1:36] !== '0)
                    report_mismatch("tdata padding", 0, m_tdata[TOUT_W-1:36]);
            end
        end
    end

    task automatic send_sample(input logic signed [15:0] v);
        int gap;
        gap = pick_gap(src_idle_pct);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_window(v);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending_windows.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        wait_idle();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            swm2_pkg::REG_WINDOW_SIZE:  cfg_k = value[swm2_pkg::WIN_BITS-1:0];
            swm2_pkg::REG_IMAGE_WIDTH:  cfg_w = value[swm2_pkg::DIM_BITS-1:0];
            swm2_pkg::REG_IMAGE_HEIGHT: cfg_h = value[swm2_pkg::DIM_BITS-1:0];
            default: ;
        endcase
        col_pos = '0;
        row_pos = '0;
        reg_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic [1:0] idx);
        logic [31:0] want;
        case (idx)
            swm2_pkg::REG_WINDOW_SIZE:  want = 32'(cfg_k);
            swm2_pkg::REG_IMAGE_WIDTH:  want = 32'(cfg_w);
            default:                    want = 32'(cfg_h);
        endcase
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want)
            report_mismatch($sformatf("readback of register %0d", idx), want, prdata);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic configure(input int k, input int w, input int h);
        if ($urandom_range(1)) begin
            write_register(swm2_pkg::REG_WINDOW_SIZE, k);
            write_register(swm2_pkg::REG_IMAGE_WIDTH, w);
            write_register(swm2_pkg::REG_IMAGE_HEIGHT, h);
        end else begin
            write_register(swm2_pkg::REG_IMAGE_HEIGHT, h);
            write_register(swm2_pkg::REG_IMAGE_WIDTH, w);
            write_register(swm2_pkg::REG_WINDOW_SIZE, k);
        end
    endtask

    task automatic test_register_access();
        check_register(swm2_pkg::REG_WINDOW_SIZE);
        check_register(swm2_pkg::REG_IMAGE_WIDTH);
        check_register(swm2_pkg::REG_IMAGE_HEIGHT);
        // upper pwdata bits must be dropped
        write_register(swm2_pkg::REG_WINDOW_SIZE, 32'hFFFF_FFFF);
        write_register(swm2_pkg::REG_IMAGE_WIDTH, 32'hA5A5_FFFF);
        write_register(swm2_pkg::REG_IMAGE_HEIGHT, 32'h5A5A_F800);
        check_register(swm2_pkg::REG_WINDOW_SIZE);
        check_register(swm2_pkg::REG_IMAGE_WIDTH);
        check_register(swm2_pkg::REG_IMAGE_HEIGHT);
        write_register(swm2_pkg::REG_WINDOW_SIZE, 32'hDEAD_BEE0);
        write_register(swm2_pkg::REG_IMAGE_WIDTH, 32'd1);
        write_register(swm2_pkg::REG_IMAGE_HEIGHT, 32'd1024);
        check_register(swm2_pkg::REG_WINDOW_SIZE);
        check_register(swm2_pkg::REG_IMAGE_WIDTH);
        check_register(swm2_pkg::REG_IMAGE_HEIGHT);
    endtask

    task automatic test_directed_windows();
        logic signed [15:0] img_a [9]  = '{-32768, 32767, 0, -1, 1, -32768, 32767, -2, 5};
        logic signed [15:0] img_b [12] = '{-32768, -32768, -32768, -32768,
                                           -32768, 32767, -32768, 100,
                                           -5, -32768, -7, 32767};
        logic signed [15:0] img_c [4]  = '{32767, -32768, 0, -1};
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        configure(2, 3, 3);
        foreach (img_a[i]) send_sample(img_a[i]);
        configure(3, 4, 3);
        foreach (img_b[i]) send_sample(img_b[i]);
        configure(1, 2, 2);
        foreach (img_c[i]) send_sample(img_c[i]);
    endtask

    task automatic test_window_exceeds_image();
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        configure(4, 3, 6);
        repeat (20) send_sample(pick_sample(0));
        configure(4, 6, 3);
        repeat (20) send_sample(pick_sample(0));
        configure(4, 4, 4);
        repeat (16) send_sample(pick_sample(2));
    endtask

    task automatic test_frame_restart();
        src_idle_pct  = 30;
        sink_idle_pct = 30;
        configure(2, 5, 4);
        repeat (7) send_sample(pick_sample(0));
        write_register(swm2_pkg::REG_IMAGE_HEIGHT, 4);
        repeat (20) send_sample(pick_sample(0));
        repeat (13) send_sample(pick_sample(1));
        write_register(swm2_pkg::REG_WINDOW_SIZE, 2);
        repeat (20) send_sample(pick_sample(1));
    endtask

    task automatic test_register_clamps();
        src_idle_pct  = 25;
        sink_idle_pct = 25;
        configure(0, 3, 2);
        repeat (6) send_sample(pick_sample(0));
        configure($urandom_range(15, 9), 9, 9);
        repeat (81) send_sample(pick_sample(0));
        configure(8, 8, 8);
        repeat (64) send_sample(pick_sample(1));
        configure(1, 0, 0);
        repeat (3) send_sample(pick_sample(2));
        // widest image, no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        configure(1, 2047, 1);
        repeat (MAX_W) send_sample(pick_sample(0));
    endtask

    task automatic test_random_frames();
        int target, k_raw, k, w, h, count, mode;
        target = samples_sent + RANDOM_ITEMS;
        while (samples_sent < target) begin
            if ($urandom_range(9) == 0)
                k_raw = $urandom_range(1) ? 0 : $urandom_range(15, 9);
            else
                k_raw = $urandom_range(MAX_WIN, 1);
            k = eff_window(swm2_pkg::WIN_BITS'(k_raw));
            if (k > 1 && $urandom_range(9) == 0)
                w = $urandom_range(k - 1, 1);
            else
                w = $urandom_range(k + 8, k);
            if (k > 1 && $urandom_range(9) == 0)
                h = $urandom_range(k - 1, 1);
            else
                h = $urandom_range(k + 8, k);
            configure(k_raw | ($urandom << swm2_pkg::WIN_BITS),
                      w | ($urandom << swm2_pkg::DIM_BITS), h);
            case ($urandom_range(2))
                0: src_idle_pct = 0;
                1: src_idle_pct = 15;
                default: src_idle_pct = 50;
            endcase
            case ($urandom_range(2))
                0: sink_idle_pct = 0;
                1: sink_idle_pct = 15;
                default: sink_idle_pct = 50;
            endcase
            if ($urandom_range(3) == 0 && w * h > 1)
                count = $urandom_range(w * h - 1, 1);
            else
                count = w * h * $urandom_range(2, 1);
            mode = $urandom_range(2);
            repeat (count) send_sample(pick_sample(mode));
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_register_access();
        test_directed_windows();
        test_window_exceeds_image();
        test_frame_restart();
        test_register_clamps();
        test_random_frames();

        wait_idle();
        $display("%0d samples sent, %0d pooled windows compared, %0d register writes",
                 samples_sent, windows_seen, reg_writes);
        $display("window sizes 0..15, images 1x1 up to 1024 wide, frame restarts");
        if (mismatches == 0) begin
            $display("sliding_window_max_2d test passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("sliding_window_max_2d test failed");
        end
        $finish;
    end

endmodule
